FILE: src/idrp_pkg.sv
// Shared types, constants and helpers of the directory record parser.
`timescale 1ns / 1ps
package idrp_pkg;

  localparam int unsigned SECTOR_BYTES = 2048;
  localparam int unsigned PAD_MARGIN   = 32;
  localparam int unsigned OFF_W        = $clog2(SECTOR_BYTES);
  localparam int unsigned PAD_LIMIT    = SECTOR_BYTES - PAD_MARGIN;

  localparam int unsigned MIN_RECORD = 34;
  localparam int unsigned NAME_POS   = 33;
  localparam int unsigned NLEN_POS   = 32;
  localparam int unsigned FLAG_POS   = 25;
  localparam int unsigned CHECK_POS  = 17;

  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // result kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  // entry types
  localparam logic [1:0] TYPE_FILE  = 2'd0;
  localparam logic [1:0] TYPE_DIR   = 2'd1;
  localparam logic [1:0] TYPE_OTHER = 2'd2;

  localparam logic [7:0] FLAGS_FILE = 8'd0;
  localparam logic [7:0] FLAGS_DIR  = 8'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] extent_start;
    logic [31:0] data_length;
    logic [1:0]  entry_type;
    logic [7:0]  name_length;
    logic [7:0]  name_byte;
    logic [7:0]  name_index;
    logic        name_done;
    logic [31:0] parent_sector;
  } result_t;

  // One queue slot: everything a single input beat produces.
  typedef struct packed {
    result_t    r0;
    logic       has_r1;
    logic [1:0] r1_kind;
  } qentry_t;

  function automatic result_t make_plain(logic [1:0] kind, logic [31:0] sector);
    result_t r;
    r               = '0;
    r.kind          = kind;
    r.parent_sector = sector;
    return r;
  endfunction

  function automatic logic [1:0] type_of(logic [7:0] flags);
    logic [1:0] t;
    if (flags == FLAGS_FILE) begin
      t = TYPE_FILE;
    end else if (flags == FLAGS_DIR) begin
      t = TYPE_DIR;
    end else begin
      t = TYPE_OTHER;
    end
    return t;
  endfunction

endpackage

FILE: src/idrp_front.sv
// Front end: tracks sector/record position per byte and builds the results of a beat.
`timescale 1ns / 1ps
module idrp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  first_byte_i,
  input  logic                  last_byte_i,
  input  logic [31:0]           dir_sector_i,
  output logic                  push_o,
  output idrp_pkg::qentry_t     entry_o
);

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_RECORD = 2'd1;
  localparam logic [1:0] MODE_SKIP   = 2'd2;
  localparam logic [1:0] MODE_HALT   = 2'd3;

  localparam int unsigned OW = idrp_pkg::OFF_W;

  logic [OW-1:0] off_q, off_d;
  logic [7:0]    pos_q, pos_d, len_q, len_d, flags_q, flags_d, nlen_q, nlen_d;
  logic [31:0]   sle_q, sle_d, sbe_q, sbe_d, lle_q, lle_d, lbe_q, lbe_d;
  logic [1:0]    seen_q, seen_d, mode_q, mode_d;
  logic [31:0]   sector_q, sector_d;

  always_comb begin
    logic [OW-1:0] off;
    logic [7:0]    pos;
    logic [8:0]    pos_inc;
    logic [7:0]    idx;
    logic [1:0]    lane;
    logic          hit;
    logic          dot;
    idrp_pkg::result_t r0;

    // a first byte restarts the parse before this byte is looked at
    off      = first_byte_i ? '0 : off_q;
    pos_d    = first_byte_i ? '0 : pos_q;
    len_d    = first_byte_i ? '0 : len_q;
    flags_d  = first_byte_i ? '0 : flags_q;
    nlen_d   = first_byte_i ? '0 : nlen_q;
    sle_d    = first_byte_i ? '0 : sle_q;
    sbe_d    = first_byte_i ? '0 : sbe_q;
    lle_d    = first_byte_i ? '0 : lle_q;
    lbe_d    = first_byte_i ? '0 : lbe_q;
    seen_d   = first_byte_i ? '0 : seen_q;
    mode_d   = first_byte_i ? MODE_START : mode_q;
    sector_d = first_byte_i ? dir_sector_i : sector_q;

    pos     = pos_d;
    pos_inc = {1'b0, pos} + 9'd1;
    idx     = pos - 8'(idrp_pkg::NAME_POS);
    lane    = 2'd0;
    hit     = 1'b0;
    dot     = 1'b0;
    r0      = '0;

    unique case (mode_d)
      MODE_START: begin
        if (off > OW'(idrp_pkg::PAD_LIMIT)) begin
          mode_d = MODE_SKIP;
        end else if (data_byte_i == 8'd0) begin
          mode_d = MODE_SKIP;
        end else if (data_byte_i < 8'(idrp_pkg::MIN_RECORD)) begin
          hit    = 1'b1;
          r0     = idrp_pkg::make_plain(idrp_pkg::KIND_BAD, sector_d);
          mode_d = MODE_HALT;
        end else begin
          len_d   = data_byte_i;
          pos_d   = 8'd1;
          sle_d   = '0;
          sbe_d   = '0;
          lle_d   = '0;
          lbe_d   = '0;
          flags_d = '0;
          nlen_d  = '0;
          mode_d  = MODE_RECORD;
        end
      end
      MODE_RECORD: begin
        if (pos >= 8'd2 && pos <= 8'd5) begin
          lane  = 2'(pos - 8'd2);
          sle_d = sle_d | (32'(data_byte_i) << {lane, 3'b000});
        end else if (pos >= 8'd6 && pos <= 8'd9) begin
          sbe_d = {sbe_d[23:0], data_byte_i};
        end else if (pos >= 8'd10 && pos <= 8'd13) begin
          lane  = 2'(pos - 8'd10);
          lle_d = lle_d | (32'(data_byte_i) << {lane, 3'b000});
        end else if (pos >= 8'd14 && pos <= 8'(idrp_pkg::CHECK_POS)) begin
          lbe_d = {lbe_d[23:0], data_byte_i};
        end else if (pos == 8'(idrp_pkg::FLAG_POS)) begin
          flags_d = data_byte_i;
        end else if (pos == 8'(idrp_pkg::NLEN_POS)) begin
          nlen_d = data_byte_i;
        end

        r0.kind          = idrp_pkg::KIND_NAME;
        r0.extent_start  = sle_d;
        r0.data_length   = lle_d;
        r0.entry_type    = idrp_pkg::type_of(flags_d);
        r0.name_length   = nlen_d;
        r0.parent_sector = sector_d;

        if (pos == 8'(idrp_pkg::CHECK_POS) && (sle_d != sbe_d || lle_d != lbe_d)) begin
          hit    = 1'b1;
          r0     = idrp_pkg::make_plain(idrp_pkg::KIND_BAD, sector_d);
          mode_d = MODE_HALT;
        end else if (pos == 8'(idrp_pkg::NLEN_POS) &&
                     (9'(idrp_pkg::NAME_POS) + {1'b0, data_byte_i}) > {1'b0, len_d}) begin
          hit    = 1'b1;
          r0     = idrp_pkg::make_plain(idrp_pkg::KIND_BAD, sector_d);
          mode_d = MODE_HALT;
        end else if (pos == 8'(idrp_pkg::NLEN_POS) && data_byte_i == 8'd0) begin
          // entry with no name: one result carries the whole entry
          hit          = 1'b1;
          r0.kind      = idrp_pkg::KIND_EMPTY;
          r0.name_done = 1'b1;
        end else if (pos >= 8'(idrp_pkg::NAME_POS) && idx < nlen_d) begin
          // '.' and '..' open a directory as one-byte names 0x00 and 0x01
          dot = (idx == 8'd0) && (seen_d < 2'd2) && (nlen_d == 8'd1) &&
                (data_byte_i == {6'd0, seen_d});
          hit          = !dot;
          r0.name_byte  = data_byte_i;
          r0.name_index = idx;
          r0.name_done  = ({1'b0, idx} + 9'd1) == {1'b0, nlen_d};
        end

        if (mode_d == MODE_RECORD) begin
          pos_d = pos_inc[7:0];
          if (pos_inc >= {1'b0, len_d}) begin
            mode_d = MODE_START;
            if (seen_d < 2'd2) begin
              seen_d = seen_d + 2'd1;
            end
          end
        end
      end
      MODE_SKIP, MODE_HALT: begin
      end
      default: begin
      end
    endcase

    off_d = (off == OW'(idrp_pkg::SECTOR_BYTES - 1)) ? '0 : off + OW'(1);
    if (mode_d == MODE_SKIP && off_d == '0) begin
      mode_d = MODE_START;
    end

    entry_o.r0      = r0;
    entry_o.has_r1  = 1'b0;
    entry_o.r1_kind = idrp_pkg::KIND_DONE;
    push_o          = accept_i && hit;
    if (last_byte_i && mode_d != MODE_HALT) begin
      if (hit) begin
        entry_o.has_r1  = 1'b1;
        entry_o.r1_kind = (mode_d == MODE_RECORD) ? idrp_pkg::KIND_BAD : idrp_pkg::KIND_DONE;
      end else begin
        entry_o.r0 = idrp_pkg::make_plain(
            (mode_d == MODE_RECORD) ? idrp_pkg::KIND_BAD : idrp_pkg::KIND_DONE, sector_d);
      end
      push_o = accept_i;
      mode_d = MODE_HALT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      pos_q    <= '0;
      len_q    <= '0;
      flags_q  <= '0;
      nlen_q   <= '0;
      sle_q    <= '0;
      sbe_q    <= '0;
      lle_q    <= '0;
      lbe_q    <= '0;
      seen_q   <= '0;
      mode_q   <= MODE_START;
      sector_q <= '0;
    end else if (accept_i) begin
      off_q    <= off_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      flags_q  <= flags_d;
      nlen_q   <= nlen_d;
      sle_q    <= sle_d;
      sbe_q    <= sbe_d;
      lle_q    <= lle_d;
      lbe_q    <= lbe_d;
      seen_q   <= seen_d;
      mode_q   <= mode_d;
      sector_q <= sector_d;
    end
  end

endmodule

FILE: src/idrp_queue.sv
// Small FIFO of per-beat result bundles between front and back end.
`timescale 1ns / 1ps
module idrp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  idrp_pkg::qentry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              nonempty_o,
  output idrp_pkg::qentry_t pop_data_o
);

  localparam int unsigned PW = idrp_pkg::QPTR_W;
  localparam int unsigned CW = idrp_pkg::QCNT_W;

  idrp_pkg::qentry_t slots_q [idrp_pkg::QDEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
    logic [PW-1:0] n;
    n = (p == PW'(idrp_pkg::QDEPTH - 1)) ? '0 : p + PW'(1);
    return n;
  endfunction

  assign full_o     = (cnt_q == CW'(idrp_pkg::QDEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign pop_data_o = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= bump(wr_q);
      end
      if (pop_i) begin
        rd_q <= bump(rd_q);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: src/idrp_back.sv
// Back end: unpacks queued bundles into single results behind an output register.
`timescale 1ns / 1ps
module idrp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_nonempty_i,
  input  idrp_pkg::qentry_t q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output idrp_pkg::result_t out_o
);

  logic              valid_q;
  logic              pend_q;
  logic [1:0]        pend_kind_q;
  idrp_pkg::result_t out_q;
  logic              load;

  assign load        = !valid_q || out_ready_i;
  assign q_pop_o     = load && !pend_q && q_nonempty_i;
  assign out_valid_o = valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      pend_q      <= 1'b0;
      pend_kind_q <= idrp_pkg::KIND_DONE;
    end else if (load) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else if (q_nonempty_i) begin
        valid_q     <= 1'b1;
        pend_q      <= q_data_i.has_r1;
        pend_kind_q <= q_data_i.r1_kind;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  // the trailing result of a beat keeps the parent sector of the first
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        out_q <= idrp_pkg::make_plain(pend_kind_q, out_q.parent_sector);
      end else if (q_nonempty_i) begin
        out_q <= q_data_i.r0;
      end
    end
  end

endmodule

FILE: src/iso9660_dir_record_parser_unit.sv
// Top level of the ISO 9660 directory record parser.
// Takes a directory extent one byte per beat and streams out name bytes of its entries
// (with extent start, data length, type and parent sector), skipping sector padding and the
// '.'/'..' entries, flagging malformed records and marking the directory end. A byte that
// yields two results (a result plus the end or malformed marker on the final byte) leaves
// the output register as two results in turn, and a two-deep queue between the front end
// and the output stage absorbs that and output stalls. Sustained rate is one byte per cycle
// while out_ready_i stays high. out_valid_o rises once the result has been written into the
// queue and then loaded into the output register.
`timescale 1ns / 1ps
module iso9660_dir_record_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] dir_sector_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] extent_start_o,
  output logic [31:0] data_length_o,
  output logic [1:0]  entry_type_o,
  output logic [7:0]  name_length_o,
  output logic [7:0]  name_byte_o,
  output logic [7:0]  name_index_o,
  output logic        name_done_o,
  output logic [31:0] parent_sector_o
);

  logic              accept;
  logic              push;
  logic              q_full;
  logic              q_nonempty;
  logic              q_pop;
  idrp_pkg::qentry_t push_data;
  idrp_pkg::qentry_t pop_data;
  idrp_pkg::result_t res;

  // a beat is taken whenever the queue has a free slot
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  idrp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .dir_sector_i (dir_sector_i),
    .push_o       (push),
    .entry_o      (push_data)
  );

  idrp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .nonempty_o  (q_nonempty),
    .pop_data_o  (pop_data)
  );

  idrp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_nonempty_i (q_nonempty),
    .q_data_i     (pop_data),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (res)
  );

  assign kind_o          = res.kind;
  assign extent_start_o  = res.extent_start;
  assign data_length_o   = res.data_length;
  assign entry_type_o    = res.entry_type;
  assign name_length_o   = res.name_length;
  assign name_byte_o     = res.name_byte;
  assign name_index_o    = res.name_index;
  assign name_done_o     = res.name_done;
  assign parent_sector_o = res.parent_sector;

endmodule

FILE: verif/iso9660_dir_record_parser_unit_tb.sv
// Self-checking testbench of the ISO 9660 directory record parser unit.
`timescale 1ns / 1ps
module iso9660_dir_record_parser_unit_tb;

  // Parser position as the scoreboard mirrors it.
  typedef enum logic [1:0] {
    PM_START,
    PM_RECORD,
    PM_SKIP,
    PM_HALT
  } parse_mode_e;

  // Shapes of record the stimulus builder can lay down.
  typedef enum int {
    REC_GOOD,
    REC_SHORT,
    REC_MISMATCH,
    REC_OVERRUN,
    REC_PAD,
    REC_JUNK
  } rec_kind_e;

  // One input beat, plus a flag that makes the sender wait for a drained output.
  typedef struct {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [31:0] sector;
    bit          drain;
  } dir_beat_t;

  localparam int STALL_LIMIT  = 2000; // cycles with no beat moving on either side
  localparam int LONG_HOLD    = 80;   // receiver hold-off that backs the unit up
  localparam int TAIL_BEATS   = 150;  // last beats run without any idling
  localparam int ITEMS        = 450;  // minimum input beats in the whole run
  localparam int SETTLE       = 20;
  localparam int OFF_BITS     = idrp_pkg::OFF_W;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        first_byte_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic [31:0] dir_sector_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] extent_start_o;
  logic [31:0] data_length_o;
  logic [1:0]  entry_type_o;
  logic [7:0]  name_length_o;
  logic [7:0]  name_byte_o;
  logic [7:0]  name_index_o;
  logic        name_done_o;
  logic [31:0] parent_sector_o;

  iso9660_dir_record_parser_unit DUT (.*);

  // Stimulus and scoreboard storage.
  dir_beat_t         extent_beats[$];     // beats waiting to be offered
  logic [7:0]        dir_bytes[$];        // directory extent under construction
  idrp_pkg::result_t parsed_results_q[$]; // results the unit still owes us
  dir_beat_t         cur_beat;
  int                bytes_taken;
  int                mismatches;
  int                run_cycles;
  int                quiet_cycles;
  int                gap_left;
  int                stall_left;
  int                hold_left;
  int                next_hold_at = 150;
  idrp_pkg::result_t got;
  idrp_pkg::result_t want;

  // Mirror of the parser state.
  logic [OFF_BITS-1:0] sec_off;
  logic [7:0]          rec_pos;
  logic [7:0]          rec_len;
  logic [31:0]         ext_le, ext_be, len_le, len_be;
  logic [7:0]          flag_val;
  logic [7:0]          nlen_val;
  logic [1:0]          dirents_done;   // saturates at two
  parse_mode_e         pmode;
  logic [31:0]         parent_sec;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard model
  // ---------------------------------------------------------------------------

  task automatic restart_dir();
    sec_off      = '0;
    rec_pos      = '0;
    rec_len      = '0;
    ext_le       = '0;
    ext_be       = '0;
    len_le       = '0;
    len_be       = '0;
    flag_val     = '0;
    nlen_val     = '0;
    dirents_done = '0;
    pmode        = PM_START;
  endtask

  task automatic owe_result(idrp_pkg::result_t r);
    parsed_results_q = {parsed_results_q, r};
  endtask

  // Done / malformed markers carry only the kind and the parent sector.
  function automatic idrp_pkg::result_t marker_result(logic [1:0] k);
    idrp_pkg::result_t r;
    r               = '0;
    r.kind          = k;
    r.parent_sector = parent_sec;
    return r;
  endfunction

  function automatic idrp_pkg::result_t entry_result(logic [1:0] k, logic [7:0] nb,
                                                     logic [7:0] idx, logic done);
    idrp_pkg::result_t r;
    r.kind          = k;
    r.extent_start  = ext_le;
    r.data_length   = len_le;
    if (flag_val == idrp_pkg::FLAGS_FILE) begin
      r.entry_type = idrp_pkg::TYPE_FILE;
    end else if (flag_val == idrp_pkg::FLAGS_DIR) begin
      r.entry_type = idrp_pkg::TYPE_DIR;
    end else begin
      r.entry_type = idrp_pkg::TYPE_OTHER;
    end
    r.name_length   = nlen_val;
    r.name_byte     = nb;
    r.name_index    = idx;
    r.name_done     = done;
    r.parent_sector = parent_sec;
    return r;
  endfunction

  // Advance the mirror by one accepted beat and queue whatever it yields.
  task automatic parse_dir_byte(dir_beat_t bt);
    logic [7:0] b;
    int         pos;
    int         idx;
    b = bt.data;
    if (bt.first) begin
      restart_dir();
      parent_sec = bt.sector;
    end
    case (pmode)
      PM_START: begin
        if (sec_off > idrp_pkg::PAD_LIMIT) begin
          pmode = PM_SKIP;               // too close to the sector end: padding
        end else if (b == 8'd0) begin
          pmode = PM_SKIP;               // zero length byte: padding
        end else if (b < idrp_pkg::MIN_RECORD) begin
          owe_result(marker_result(idrp_pkg::KIND_BAD));
          pmode = PM_HALT;
        end else begin
          rec_len  = b;
          rec_pos  = 8'd1;
          ext_le   = '0;
          ext_be   = '0;
          len_le   = '0;
          len_be   = '0;
          flag_val = '0;
          nlen_val = '0;
          pmode    = PM_RECORD;
        end
      end
      PM_RECORD: begin
        pos = int'(rec_pos);
        if (pos >= 2 && pos <= 5) begin
          ext_le = ext_le | (32'(b) << (8 * (pos - 2)));
        end else if (pos >= 6 && pos <= 9) begin
          ext_be = {ext_be[23:0], b};
        end else if (pos >= 10 && pos <= 13) begin
          len_le = len_le | (32'(b) << (8 * (pos - 10)));
        end else if (pos >= 14 && pos <= 17) begin
          len_be = {len_be[23:0], b};
        end else if (pos == int'(idrp_pkg::FLAG_POS)) begin
          flag_val = b;
        end else if (pos == int'(idrp_pkg::NLEN_POS)) begin
          nlen_val = b;
        end

        if (pos == int'(idrp_pkg::CHECK_POS) && (ext_le != ext_be || len_le != len_be)) begin
          owe_result(marker_result(idrp_pkg::KIND_BAD));
          pmode = PM_HALT;
        end else if (pos == int'(idrp_pkg::NLEN_POS) &&
                     int'(idrp_pkg::NAME_POS) + int'(b) > int'(rec_len)) begin
          owe_result(marker_result(idrp_pkg::KIND_BAD));   // name runs past record
          pmode = PM_HALT;
        end else if (pos == int'(idrp_pkg::NLEN_POS) && b == 8'd0) begin
          owe_result(entry_result(idrp_pkg::KIND_EMPTY, 8'd0, 8'd0, 1'b1));
        end else if (pos >= int'(idrp_pkg::NAME_POS) &&
                     pos - int'(idrp_pkg::NAME_POS) < int'(nlen_val)) begin
          idx = pos - int'(idrp_pkg::NAME_POS);
          // '.' and '..' open a directory and are dropped
          if (!(idx == 0 && dirents_done < 2'd2 && nlen_val == 8'd1 &&
                b == 8'(dirents_done))) begin
            owe_result(entry_result(idrp_pkg::KIND_NAME, b, 8'(idx),
                                    idx + 1 == int'(nlen_val)));
          end
        end

        if (pmode == PM_RECORD) begin
          rec_pos = 8'(pos + 1);
          if (pos + 1 >= int'(rec_len)) begin
            pmode = PM_START;
            if (dirents_done < 2'd2) dirents_done = dirents_done + 2'd1;
          end
        end
      end
      default: ;
    endcase

    if (sec_off == OFF_BITS'(idrp_pkg::SECTOR_BYTES - 1)) begin
      sec_off = '0;
    end else begin
      sec_off = sec_off + 1'b1;
    end
    if (pmode == PM_SKIP && sec_off == '0) pmode = PM_START;

    if (bt.last && pmode != PM_HALT) begin
      owe_result(marker_result(pmode == PM_RECORD ? idrp_pkg::KIND_BAD
                                                  : idrp_pkg::KIND_DONE));
      pmode = PM_HALT;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builder
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 7))
      0:       w = 32'h0000_0000;
      1:       w = 32'hFFFF_FFFF;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic int pick_flags();
    int f;
    case ($urandom_range(0, 3))
      0:       f = int'(idrp_pkg::FLAGS_FILE);
      1:       f = int'(idrp_pkg::FLAGS_DIR);
      default: f = $urandom_range(0, 255);
    endcase
    return f;
  endfunction

  task automatic add_byte(logic [7:0] v);
    dir_bytes = {dir_bytes, v};
  endtask

  // Bytes the parser steps over.
  task automatic add_fill(int n);
    repeat (n) add_byte(8'($urandom));
  endtask

  // Append one record; -1 in flags, nlen or name0 means pick at random.
  task automatic add_record(rec_kind_e kind, int flags, int nlen, int name0);
    int          off, len, nl, tail, base, fl, n, nlb;
    logic [31:0] ext, dl;
    logic [7:0]  b;
    off = dir_bytes.size() % idrp_pkg::SECTOR_BYTES;
    if (off > int'(idrp_pkg::PAD_LIMIT)) add_fill(idrp_pkg::SECTOR_BYTES - off);
    base = dir_bytes.size();
    case (kind)
      REC_PAD: begin
        // zero length byte: the rest of the sector is skipped
        add_byte(8'h00);
        add_fill($urandom_range(0, 20));
      end
      REC_SHORT: begin
        add_byte(8'($urandom_range(1, idrp_pkg::MIN_RECORD - 1)));
        add_fill($urandom_range(0, 6));
      end
      REC_JUNK: begin
        n = $urandom_range(1, 40);
        repeat (n) add_byte(8'($urandom));
      end
      default: begin
        if (nlen >= 0) begin
          nl = nlen;
        end else if ($urandom_range(0, 9) == 0) begin
          nl = $urandom_range(13, 100);
        end else begin
          nl = $urandom_range(0, 8);
        end
        tail = $urandom_range(0, 1) ? 0 : $urandom_range(0, 8);
        if (nl + tail == 0) tail = 1;
        if (33 + nl + tail > 255) tail = 222 - nl;
        len = 33 + nl + tail;
        ext = pick_word();
        dl  = pick_word();
        fl  = (flags >= 0) ? flags : pick_flags();
        nlb = (kind == REC_OVERRUN) ? $urandom_range(len - 32, 255) : nl;
        for (int j = 0; j < len; j++) begin
          if (j == 0) begin
            b = 8'(len);
          end else if (j >= 2 && j <= 5) begin
            b = ext[8 * (j - 2) +: 8];
          end else if (j >= 6 && j <= 9) begin
            b = ext[8 * (9 - j) +: 8];       // big-endian copy
          end else if (j >= 10 && j <= 13) begin
            b = dl[8 * (j - 10) +: 8];
          end else if (j >= 14 && j <= 17) begin
            b = dl[8 * (17 - j) +: 8];
          end else if (j == int'(idrp_pkg::FLAG_POS)) begin
            b = 8'(fl);
          end else if (j == int'(idrp_pkg::NLEN_POS)) begin
            b = 8'(nlb);
          end else if (j == int'(idrp_pkg::NAME_POS) && name0 >= 0) begin
            b = 8'(name0);
          end else begin
            b = 8'($urandom);
          end
          add_byte(b);
        end
        if (kind == REC_MISMATCH) begin
          // one flipped bit in a single copy breaks the pair
          n = base + $urandom_range(2, idrp_pkg::CHECK_POS);
          dir_bytes[n] = dir_bytes[n] ^ (8'h01 << $urandom_range(0, 7));
        end
      end
    endcase
  endtask

  // Turn the built extent into beats, then a little noise before the next one.
  task automatic emit_directory(logic [31:0] sector, bit with_first, bit drain);
    dir_beat_t bt;
    if (dir_bytes.size() == 0) add_byte(8'($urandom));
    foreach (dir_bytes[i]) begin
      bt.data   = dir_bytes[i];
      bt.first  = with_first && i == 0;
      bt.last   = (i == dir_bytes.size() - 1);
      bt.sector = bt.first ? sector : $urandom;
      bt.drain  = drain && i == 0;
      extent_beats = {extent_beats, bt};
    end
    dir_bytes.delete();
    repeat ($urandom_range(0, 3)) begin
      bt.data   = $urandom;
      bt.first  = 1'b0;
      bt.last   = $urandom;
      bt.sector = $urandom;
      bt.drain  = 1'b0;
      extent_beats = {extent_beats, bt};
    end
  endtask

  task automatic queue_random_dir();
    int nrec, mark, cut;
    nrec = $urandom_range(0, 4);
    mark = 0;
    for (int i = 0; i < nrec; i++) begin
      mark = dir_bytes.size();
      if ($urandom_range(0, 99) < 15) begin
        case ($urandom_range(0, 4))
          0:       add_record(REC_SHORT, -1, -1, -1);
          1:       add_record(REC_MISMATCH, -1, -1, -1);
          2:       add_record(REC_OVERRUN, -1, -1, -1);
          3:       add_record(REC_PAD, -1, -1, -1);
          default: add_record(REC_JUNK, -1, -1, -1);
        endcase
      end else if (i < 2 && $urandom_range(0, 9) < 7) begin
        // dot entries, now and then in the wrong order
        add_record(REC_GOOD, -1, 1, ($urandom_range(0, 7) == 0) ? 1 - i : i);
      end else begin
        add_record(REC_GOOD, -1, -1, -1);
      end
    end
    case ($urandom_range(0, 9))
      0, 1: begin
        // directory ends inside the last record
        if (dir_bytes.size() - mark > 1) begin
          cut = $urandom_range(1, dir_bytes.size() - mark - 1);
          dir_bytes = dir_bytes[0:$-cut];
        end
      end
      2: begin
        add_byte(8'h00);
        add_fill($urandom_range(0, 20));
      end
      default: ;
    endcase
    emit_directory(pick_word(), 1'b1, $urandom_range(0, 7) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offers queued beats, idles in bursts, waits for a drain when asked
  // ---------------------------------------------------------------------------

  function automatic bit idle_ok();
    return extent_beats.size() > TAIL_BEATS && run_cycles[8:7] != 2'b11;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        parse_dir_byte(cur_beat);
        bytes_taken++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (extent_beats.size() == 0 ||
                     (extent_beats[0].drain && parsed_results_q.size() != 0)) begin
          in_valid_i <= 1'b0;
        end else if (idle_ok() && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(1, 12) - 1;
          in_valid_i <= 1'b0;
        end else begin
          cur_beat = extent_beats[0];
          extent_beats.delete(0);
          in_valid_i   <= 1'b1;
          data_byte_i  <= cur_beat.data;
          first_byte_i <= cur_beat.first;
          last_byte_i  <= cur_beat.last;
          dir_sector_i <= cur_beat.sector;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each result beat, stalls in bursts and once in a while
  // holds off long enough to fill the unit and push back on the input
  // ---------------------------------------------------------------------------

  function automatic void check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{kind_o, extent_start_o, data_length_o, entry_type_o, name_length_o,
                name_byte_o, name_index_o, name_done_o, parent_sector_o};
        if (parsed_results_q.size() == 0) begin
          $error("result beat with nothing pending: kind %0d", kind_o);
          mismatches++;
        end else begin
          want = parsed_results_q[0];
          parsed_results_q.delete(0);
          check_field("kind", 32'(want.kind), 32'(got.kind));
          check_field("extent_start", want.extent_start, got.extent_start);
          check_field("data_length", want.data_length, got.data_length);
          check_field("entry_type", 32'(want.entry_type), 32'(got.entry_type));
          check_field("name_length", 32'(want.name_length), 32'(got.name_length));
          check_field("name_byte", 32'(want.name_byte), 32'(got.name_byte));
          check_field("name_index", 32'(want.name_index), 32'(got.name_index));
          check_field("name_done", 32'(want.name_done), 32'(got.name_done));
          check_field("parent_sector", want.parent_sector, got.parent_sector);
        end
      end
      if (hold_left == 0 && extent_beats.size() > TAIL_BEATS &&
          bytes_taken >= next_hold_at) begin
        hold_left = LONG_HOLD;
        next_hold_at = next_hold_at + 900;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_ok() && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      run_cycles++;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build all stimulus, reset, run to drain, report
  // ---------------------------------------------------------------------------

  initial begin
    restart_dir();
    parent_sec = '0;

    // No first byte after reset: dot entries, then a name that ends the extent.
    add_record(REC_GOOD, int'(idrp_pkg::FLAGS_FILE), 1, 0);
    add_record(REC_GOOD, int'(idrp_pkg::FLAGS_DIR), 1, 1);
    add_record(REC_GOOD, 8'h81, 3, -1);
    emit_directory(32'h0, 1'b0, 1'b0);
    // Empty name, odd flags, then a padding byte; sender drains first.
    add_record(REC_GOOD, int'(idrp_pkg::FLAGS_DIR), 0, -1);
    add_record(REC_GOOD, 255, 5, -1);
    add_record(REC_PAD, -1, -1, -1);
    emit_directory(32'hFFFF_FFFF, 1'b1, 1'b1);
    add_record(REC_SHORT, -1, -1, -1);
    emit_directory(32'h0, 1'b1, 1'b0);
    add_record(REC_MISMATCH, -1, -1, -1);
    emit_directory($urandom, 1'b1, 1'b0);
    add_record(REC_OVERRUN, -1, -1, -1);
    emit_directory($urandom, 1'b1, 1'b0);
    // One-byte directories: a padding byte, then a record cut at once.
    add_byte(8'h00);
    emit_directory($urandom, 1'b1, 1'b0);
    add_byte(8'hFF);
    emit_directory($urandom, 1'b1, 1'b0);
    // Record cut a few bytes short of its end.
    add_record(REC_GOOD, -1, 4, -1);
    dir_bytes = dir_bytes[0:$-5];
    emit_directory($urandom, 1'b1, 1'b0);

    while (extent_beats.size() < ITEMS) queue_random_dir();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (extent_beats.size() != 0 || in_valid_i || parsed_results_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);

    if (mismatches == 0 && parsed_results_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/idrp_pkg.sv
src/idrp_front.sv
src/idrp_queue.sv
src/idrp_back.sv
src/iso9660_dir_record_parser_unit.sv
verif/iso9660_dir_record_parser_unit_tb.sv
